// ===== hw/rtl/u8dec_pkg.sv =====
package u8dec_pkg;

   // decode mode register codes; the unused code decodes as strict ascii
   typedef enum logic [1:0] {
      MODE_UTF8         = 2'd0,
      MODE_ASCII_LOOSE  = 2'd1,
      MODE_ASCII_STRICT = 2'd2
   } mode_type;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned CodeWidth    = 16;
   localparam int unsigned PartialWidth = 10;
   localparam int unsigned PendWidth    = 2;

   // one input beat
   typedef struct packed {
      logic [ByteWidth-1:0] in_byte;
      logic                 in_last;
   } req_type;

   // one result beat
   typedef struct packed {
      logic [CodeWidth-1:0] code_point;
      logic                 decode_error;
      logic                 out_last;
   } rsp_type;

endpackage

// ===== hw/rtl/utf8_ascii_byte_decoder_core.sv =====
// channel | ports                            | beat moves when
// --------+----------------------------------+---------------------------
// input   | req_valid, req_stall, req_data   | req_valid & !req_stall
// result  | rsp_valid, rsp_stall, rsp_data   | rsp_valid & !rsp_stall
// config  | csr_wr_en, csr_wr_data           | csr_wr_en
//
// one byte per cycle sustained while rsp_stall is low; an accepted byte goes into the
// input register, then is decoded into the result register.
// the input register takes a new byte while a finished result is held by rsp_stall;
// req_stall rises only when both registers are full and the result side is stalled.
// synchronous active-high reset clears the decode state, the mode and both valid flags.
module utf8_ascii_byte_decoder_core
   import u8dec_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  req_type    req_data,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_wr_data
);

   mode_type                mode_ff;
   logic                    in_valid_ff, in_valid_in;
   req_type                 in_data_ff;
   logic                    rsp_valid_ff, rsp_valid_in;
   rsp_type                 rsp_data_ff, rsp_data_in;
   logic [PendWidth-1:0]    pending_ff, pending_in;
   logic [PartialWidth-1:0] partial_ff, partial_in;
   logic                    discard_ff, discard_in;

   logic                    advance, req_accept, emit;
   logic [ByteWidth-1:0]    b;
   logic                    last;
   logic [CodeWidth-1:0]    cont_cp;
   logic [PendWidth-1:0]    pend_dec;

   // the decode stage moves when the result register is free or being emptied
   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign req_stall  = in_valid_ff && !advance;
   assign req_accept = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign b        = in_data_ff.in_byte;
   assign last     = in_data_ff.in_last;
   assign cont_cp  = {partial_ff, b[5:0]};
   assign pend_dec = pending_ff - PendWidth'(1);

   // decode of the byte in the input register
   always_comb begin
      emit        = 1'b0;
      rsp_data_in = '{code_point: '0, decode_error: 1'b0, out_last: last};
      pending_in  = pending_ff;
      partial_in  = partial_ff;
      discard_in  = discard_ff;

      if (discard_ff) begin
         // dropping the rest of a failed string
         if (last) begin
            discard_in = 1'b0;
            pending_in = '0;
            partial_in = '0;
         end
      end else if (mode_ff == MODE_UTF8) begin
         if (pending_ff != '0) begin
            // continuation byte
            pending_in = pend_dec;
            if (pend_dec == '0) begin
               emit                   = 1'b1;
               rsp_data_in.code_point = cont_cp;
               partial_in             = '0;
            end else if (last) begin
               emit        = 1'b1;
               rsp_data_in = '{code_point: '0, decode_error: 1'b1, out_last: 1'b1};
            end else begin
               partial_in = cont_cp[PartialWidth-1:0];
            end
         end else if (!b[7]) begin
            emit                   = 1'b1;
            rsp_data_in.code_point = CodeWidth'(b[6:0]);
         end else if (b[7:5] == 3'b110 && !last) begin
            pending_in = PendWidth'(1);
            partial_in = PartialWidth'(b[4:0]);
         end else if (b[7:4] == 4'b1110 && !last) begin
            pending_in = PendWidth'(2);
            partial_in = PartialWidth'(b[3:0]);
         end else begin
            // bad lead byte or a sequence cut short
            emit        = 1'b1;
            rsp_data_in = '{code_point: '0, decode_error: 1'b1, out_last: 1'b1};
            pending_in  = '0;
            partial_in  = '0;
            discard_in  = !last;
         end
      end else begin
         // ascii modes
         pending_in = '0;
         partial_in = '0;
         emit       = 1'b1;
         if (mode_ff == MODE_ASCII_LOOSE || !b[7]) begin
            rsp_data_in.code_point = CodeWidth'(b);
         end else begin
            rsp_data_in = '{code_point: '0, decode_error: 1'b1, out_last: 1'b1};
            discard_in  = !last;
         end
      end

      if (last) begin
         pending_in = '0;
         partial_in = '0;
         discard_in = 1'b0;
      end
   end

   // valid flags
   always_comb begin
      in_valid_in  = req_accept || (in_valid_ff && !advance);
      rsp_valid_in = advance ? (in_valid_ff && emit) : rsp_valid_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UTF8;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pending_ff   <= '0;
         partial_ff   <= '0;
         discard_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            mode_ff <= mode_type'(csr_wr_data);
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (in_valid_ff && advance) begin
            pending_ff <= pending_in;
            partial_ff <= partial_in;
            discard_ff <= discard_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_data_ff <= req_data;
      end
      if (advance && in_valid_ff && emit) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // an error beat always closes its string with a zero code point
   a_error_beat : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.decode_error |->
         rsp_data_ff.code_point == '0 && rsp_data_ff.out_last)
      else $error("error beat not zero or not last");

   // a pending sequence never needs more than two continuation bytes
   a_pending_range : assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("pending count out of range");

   // while dropping a failed string no sequence is open
   a_discard_clean : assert property (@(posedge clock) disable iff (reset)
      discard_ff |-> pending_ff == '0 && partial_ff == '0)
      else $error("open sequence while discarding");

   // a byte that enters the decode stage leaves it on the next edge if the output moves
   a_stage_moves : assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && advance && !req_accept |=> !in_valid_ff)
      else $error("input register held without a stall");

endmodule
